[design/pal22_pkg.sv]
// Shared types and constants for the PAL 2:2 pulldown detector.
package pal22_pkg;

  localparam int unsigned STAT_BITS_DEF = 24;
  localparam int unsigned CFG_STAT_W    = 24;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 24;

  localparam int unsigned PCT_W      = 7;
  localparam int unsigned LOCK_W     = 4;
  localparam int unsigned RUN_W      = 6;
  localparam int unsigned FSS_W      = 15;
  localparam int unsigned UNSURE_W   = 8;
  localparam int unsigned CCNT_W     = 10;
  localparam int unsigned TIME_W     = 32;

  localparam logic [PCT_W-1:0]    PCT_SCALE     = 7'd100;
  localparam logic [TIME_W-1:0]   HIT_GAP_MS    = 32'd100;
  localparam logic [FSS_W-1:0]    FSS_SAT       = 15'h7FFF;
  localparam logic [FSS_W-1:0]    FSS_LOCK_MIN  = 15'd100;
  localparam logic [UNSURE_W-1:0] UNSURE_SAT    = 8'd255;
  localparam logic [UNSURE_W-1:0] UNSURE_LIMIT  = 8'd3;
  localparam logic [CCNT_W-1:0]   CCNT_SAT      = 10'd1001;

  // Register reset values
  localparam logic [PCT_W-1:0]      DROP_PCT_RST   = 7'd30;
  localparam logic [CFG_STAT_W-1:0] MOVE_MIN_RST   = 24'd100;
  localparam logic [CFG_STAT_W-1:0] COMB_MIN_RST   = 24'd150;
  localparam logic [LOCK_W-1:0]     REPEATS_RST    = 4'd3;
  localparam logic [CFG_STAT_W-1:0] MISMATCH_RST   = 24'd100;
  localparam logic [CFG_STAT_W-1:0] RISE_MARG_RST  = 24'd300;
  localparam logic [CCNT_W-1:0]     COMB_MAX_RST   = 10'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DROP_PCT   = 3'd0,
    CFG_MOVE_MIN   = 3'd1,
    CFG_COMB_MIN   = 3'd2,
    CFG_REPEATS    = 3'd3,
    CFG_MISMATCH   = 3'd4,
    CFG_RISE_MARG  = 3'd5,
    CFG_FALLBACK   = 3'd6,
    CFG_COMB_MAX   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_VIDEO = 2'd0,
    MODE_ODD   = 2'd1,
    MODE_EVEN  = 2'd2,
    MODE_COMB  = 2'd3
  } mode_e;

  // Polarity code: 0 even, 1 odd, 2 none yet
  localparam logic [1:0] POL_NONE = 2'd2;

  typedef struct packed {
    logic [PCT_W-1:0]      drop_pct;
    logic [CFG_STAT_W-1:0] move_min;
    logic [CFG_STAT_W-1:0] comb_min;
    logic [LOCK_W-1:0]     repeats;
    logic [CFG_STAT_W-1:0] mismatch_min;
    logic [CFG_STAT_W-1:0] rise_margin;
    logic                  fallback;
    logic [CCNT_W-1:0]     comb_max;
  } cfg_t;

  // Reload of the required repeat count on a lock count write
  typedef struct packed {
    logic              load;
    logic [LOCK_W-1:0] value;
  } lock_load_t;

  typedef struct packed {
    mode_e mode;
    logic  mode_changed;
    logic  lock_harder;
  } res_t;

endpackage

[design/pal22_if.sv]
// Valid/ready channel interfaces for field statistics and mode results.
interface pal22_in_if
  import pal22_pkg::*;
#(
  parameter int unsigned STAT_BITS = STAT_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 stats_valid;
  logic [STAT_BITS-1:0] comb_factor;
  logic [STAT_BITS-1:0] field_diff;
  logic                 odd_field;
  logic [TIME_W-1:0]    now_ms;

  modport source (
    output valid, stats_valid, comb_factor, field_diff, odd_field, now_ms,
    input  ready
  );
  modport sink (
    input  valid, stats_valid, comb_factor, field_diff, odd_field, now_ms,
    output ready
  );
endinterface

interface pal22_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       mode_changed;
  logic       lock_harder;

  modport source (
    output valid, mode, mode_changed, lock_harder,
    input  ready
  );
  modport sink (
    input  valid, mode, mode_changed, lock_harder,
    output ready
  );
endinterface

[design/pal22_cfg.sv]
// Configuration register file with lock count reload strobe.
module pal22_cfg
  import pal22_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o,
  output lock_load_t            lock_load_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DROP_PCT:  cfg_d.drop_pct     = cfg_data_i[PCT_W-1:0];
        CFG_MOVE_MIN:  cfg_d.move_min     = cfg_data_i[CFG_STAT_W-1:0];
        CFG_COMB_MIN:  cfg_d.comb_min     = cfg_data_i[CFG_STAT_W-1:0];
        CFG_REPEATS:   cfg_d.repeats      = cfg_data_i[LOCK_W-1:0];
        CFG_MISMATCH:  cfg_d.mismatch_min = cfg_data_i[CFG_STAT_W-1:0];
        CFG_RISE_MARG: cfg_d.rise_margin  = cfg_data_i[CFG_STAT_W-1:0];
        CFG_FALLBACK:  cfg_d.fallback     = cfg_data_i[0];
        CFG_COMB_MAX:  cfg_d.comb_max     = cfg_data_i[CCNT_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drop_pct     <= DROP_PCT_RST;
      cfg_q.move_min     <= MOVE_MIN_RST;
      cfg_q.comb_min     <= COMB_MIN_RST;
      cfg_q.repeats      <= REPEATS_RST;
      cfg_q.mismatch_min <= MISMATCH_RST;
      cfg_q.rise_margin  <= RISE_MARG_RST;
      cfg_q.fallback     <= 1'b0;
      cfg_q.comb_max     <= COMB_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o             = cfg_q;
  assign lock_load_o.load  = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_REPEATS);
  assign lock_load_o.value = cfg_data_i[LOCK_W-1:0];

endmodule

[design/pal22_core.sv]
// Cadence detection state and single-pass next-state logic.
module pal22_core
  import pal22_pkg::*;
#(
  parameter int unsigned STAT_BITS = STAT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  lock_load_t           lock_load_i,
  input  logic                 step_i,
  input  logic                 stats_valid_i,
  input  logic [STAT_BITS-1:0] comb_factor_i,
  input  logic [STAT_BITS-1:0] field_diff_i,
  input  logic                 odd_field_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  output res_t                 res_o
);

  localparam int unsigned CW = ((STAT_BITS > CFG_STAT_W) ? STAT_BITS : CFG_STAT_W) + 1;
  localparam int unsigned PW = STAT_BITS + 8;

  typedef struct packed {
    mode_e                mode;
    logic [STAT_BITS-1:0] prev_comb;
    logic                 prev_above;
    logic [1:0]           prev_pol;
    logic [RUN_W-1:0]     run;
    logic [RUN_W-1:0]     needed;
    logic [TIME_W-1:0]    last_hit;
    logic [FSS_W-1:0]     fss;
    logic [UNSURE_W-1:0]  unsure;
    logic                 pending;
    logic [CCNT_W-1:0]    ccnt;
  } st_t;

  st_t st_q, st_d;

  function automatic st_t leave_film(st_t s, cfg_t c);
    st_t r;
    r = s;
    if (c.fallback) begin
      r.mode = MODE_VIDEO;
      r.run  = '0;
    end else if (s.fss < FSS_LOCK_MIN) begin
      r.mode   = MODE_VIDEO;
      r.fss    = '0;
      r.needed = {c.repeats, 2'b00};
      r.run    = '0;
    end else begin
      r.ccnt    = '0;
      r.mode    = MODE_COMB;
      r.run     = s.needed;
      r.pending = 1'b1;
    end
    return r;
  endfunction

  logic [PW-1:0] scaled, limit;
  logic          dropped, above, same_pol, hit, in_time;
  logic [CW-1:0] comb_w, diff_w, last_w, sum_w;

  always_comb begin
    scaled   = PW'(comb_factor_i) * PW'(PCT_SCALE);
    limit    = PW'(cfg_i.drop_pct) * (PW'(st_q.prev_comb) + PW'(PCT_SCALE));
    dropped  = scaled < limit;
    above    = scaled > limit;
    same_pol = st_q.prev_pol == {1'b0, odd_field_i};
    comb_w   = CW'(comb_factor_i);
    diff_w   = CW'(field_diff_i);
    last_w   = CW'(st_q.prev_comb);
    sum_w    = last_w + CW'(cfg_i.rise_margin);
    hit      = dropped && st_q.prev_above && (diff_w > CW'(cfg_i.move_min))
               && (last_w > CW'(cfg_i.comb_min));
    in_time  = (now_ms_i - st_q.last_hit) < HIT_GAP_MS;
  end

  always_comb begin
    st_d = st_q;
    if (stats_valid_i) begin
      if (st_d.fss < FSS_SAT) st_d.fss = st_d.fss + 1'b1;

      if (st_q.pending) begin
        if (st_q.mode == MODE_VIDEO) begin
          st_d.run     = '0;
          st_d.pending = 1'b0;
        end else if (st_q.mode != MODE_COMB) begin
          st_d.pending = 1'b0;
        end
      end

      if (st_q.mode == MODE_VIDEO || st_q.mode == MODE_COMB) begin
        if (hit) begin
          if (same_pol) begin
            if (st_d.run < st_d.needed) begin
              if (st_d.run == '0) st_d.run = RUN_W'(1);
              else if (in_time)   st_d.run = st_d.run + 1'b1;
              else                st_d.run = RUN_W'(1);
            end else if (st_d.fss > FSS_LOCK_MIN || st_q.mode == MODE_COMB) begin
              st_d.mode   = odd_field_i ? MODE_ODD : MODE_EVEN;
              st_d.needed = RUN_W'(cfg_i.repeats);
              st_d.unsure = '0;
              st_d.fss    = '0;
            end
          end else begin
            st_d.prev_pol = {1'b0, odd_field_i};
            st_d.run      = RUN_W'(1);
          end
          st_d.last_hit = now_ms_i;
        end
      end else begin
        // film mode: artefact check, then the not-sure count
        if (diff_w >= CW'(cfg_i.mismatch_min) && same_pol && comb_w > sum_w
            && comb_w > CW'(cfg_i.rise_margin)) begin
          st_d = leave_film(st_d, cfg_i);
        end
        if (same_pol && diff_w >= CW'(cfg_i.mismatch_min)) begin
          if (comb_w < last_w) begin
            if ((comb_w + CW'(cfg_i.rise_margin)) < last_w) st_d.unsure = '0;
            else if (st_d.unsure != '0) st_d.unsure = st_d.unsure - 1'b1;
          end else begin
            if (st_d.unsure < UNSURE_SAT) st_d.unsure = st_d.unsure + 1'b1;
            if (st_d.unsure > UNSURE_LIMIT) st_d = leave_film(st_d, cfg_i);
          end
        end
      end

      st_d.prev_above = above;
      st_d.prev_comb  = comb_factor_i;

      if (st_d.mode == MODE_COMB) begin
        if (st_d.ccnt < CCNT_SAT) st_d.ccnt = st_d.ccnt + 1'b1;
        if (st_d.ccnt > cfg_i.comb_max) st_d.mode = MODE_VIDEO;
      end
    end
  end

  always_comb begin
    res_o.mode         = st_d.mode;
    res_o.mode_changed = st_d.mode != st_q.mode;
    res_o.lock_harder  = st_d.needed != RUN_W'(cfg_i.repeats);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode       <= MODE_VIDEO;
      st_q.prev_comb  <= '0;
      st_q.prev_above <= 1'b0;
      st_q.prev_pol   <= POL_NONE;
      st_q.run        <= '0;
      st_q.needed     <= RUN_W'(REPEATS_RST);
      st_q.last_hit   <= '0;
      st_q.fss        <= '0;
      st_q.unsure     <= '0;
      st_q.pending    <= 1'b0;
      st_q.ccnt       <= '0;
    end else begin
      if (step_i) st_q <= st_d;
      if (lock_load_i.load) st_q.needed <= RUN_W'(lock_load_i.value);
    end
  end

  a_mode_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(st_q.mode))
    else $error("mode moved without a processed field");

  a_ccnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.ccnt <= CCNT_SAT)
    else $error("comb field count beyond saturation");

  a_needed_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.needed == RUN_W'(cfg_i.repeats)) ||
    (st_q.needed == RUN_W'({cfg_i.repeats, 2'b00})))
    else $error("required repeat count is neither normal nor quadrupled");

  a_skip_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !stats_valid_i) |=> $stable(st_q))
    else $error("skipped field altered the state");

endmodule

[design/pal22_22_pulldown_detector.sv]
// Top level of the PAL 2:2 pulldown detector: channels, pipeline and config.
//
// Usage: one beat on in_i per video field carries the field's comb factor,
// field difference, polarity and millisecond time stamp; for each such beat
// exactly one beat leaves on out_o with the deinterlace mode (video, film
// odd, film even, film comb), a mode-changed flag and the lock-harder flag.
// A beat with stats_valid low is passed through: it reports the current
// mode with mode_changed low and leaves the state untouched.
//
// An accepted beat is held in the input register; the detection logic
// and the state update then land in the result register, which drives
// out_o.valid.
// Throughput: one beat per cycle while the receiver does not stall, set
// by the single pass of the state update logic.
// Reset (rst_ni low, asynchronous) returns the config and state registers to
// their default values, the mode to video and empties both pipeline stages.
// When the receiver stalls, the result register holds its beat and one
// more beat can be taken into the input register; then in_i.ready drops.
// The user must write registers through cfg_we_i/cfg_idx_i/cfg_data_i only while idle; the block does not enforce this.
module pal_22_pulldown_detector
  import pal22_pkg::*;
#(
  parameter int unsigned STAT_BITS = STAT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pal22_in_if.sink              in_i,
  pal22_out_if.source           out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t       cfg;
  lock_load_t lock_load;
  res_t       res;

  // input register stage
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_stats_q;
  logic [STAT_BITS-1:0] s1_comb_q;
  logic [STAT_BITS-1:0] s1_diff_q;
  logic                 s1_odd_q;
  logic [TIME_W-1:0]    s1_now_q;

  // result register stage
  logic out_valid_q, out_valid_d;
  res_t out_res_q;

  logic out_free, advance, accept;

  assign out_free    = !out_valid_q || out_o.ready;
  assign advance     = s1_valid_q && out_free;   // field goes through the logic
  assign in_i.ready  = !s1_valid_q || advance;
  assign accept      = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept)       s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (advance)          out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_stats_q <= in_i.stats_valid;
      s1_comb_q  <= in_i.comb_factor;
      s1_diff_q  <= in_i.field_diff;
      s1_odd_q   <= in_i.odd_field;
      s1_now_q   <= in_i.now_ms;
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  pal22_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .lock_load_o (lock_load)
  );

  pal22_core #(
    .STAT_BITS (STAT_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .lock_load_i   (lock_load),
    .step_i        (advance),
    .stats_valid_i (s1_stats_q),
    .comb_factor_i (s1_comb_q),
    .field_diff_i  (s1_diff_q),
    .odd_field_i   (s1_odd_q),
    .now_ms_i      (s1_now_q),
    .res_o         (res)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.mode         = out_res_q.mode;
  assign out_o.mode_changed = out_res_q.mode_changed;
  assign out_o.lock_harder  = out_res_q.lock_harder;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !advance)
    else $error("pending result overwritten");

  a_s1_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |-> !accept)
    else $error("input stage overwritten while its beat waits");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed field produced no result beat");

endmodule

[tb/tb.sv]
// Self-checking bench for the PAL 2:2 pulldown detector: directed table, then random cadence runs.
module tb;
  import pal22_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Run shape
  // ---------------------------------------------------------------------------
  localparam int N_PHASES        = 5;     // register settings after the directed part
  localparam int FIELDS_PER_PH   = 290;   // valid fields per setting, about 1450 in all
  localparam int IDLE_PCT        = 36;    // per-cycle idling chance on both sides
  localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
  localparam int HOLD_AT         = 100;   // field of phase 1 where the hold-off starts
  localparam int PAUSE_AT        = 150;   // field of phase 0 where the sender drains
  localparam int STALL_LIMIT     = 4000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES     = 8;     // tail after the final drain
  localparam int MAX_REPORTS     = 60;    // cap on printed mismatch lines

  typedef struct packed {
    logic                     sv;
    logic [CFG_STAT_W-1:0]    comb;
    logic [CFG_STAT_W-1:0]    diff;
    logic                     odd;
    logic [TIME_W-1:0]        now;
  } field_t;

  // Directed row: chk set means the result below is the one to expect
  typedef struct packed {
    logic   chk;
    res_t   exp_res;
    field_t f;
  } dir_row_t;

  typedef enum logic [1:0] {
    GEN_CADENCE,   // clean 2:2 comb pattern, drives lock-in
    GEN_NOISY,     // cadence with broken fields, drives film exit
    GEN_RANDOM     // unstructured stats over the whole range
  } gen_kind_e;

  localparam res_t R_VID = '{MODE_VIDEO, 1'b0, 1'b0};

  // Directed table. High/low comb pairs build cadence hits; the rows below
  // cover the skipped field, full-scale stats, in-time and late hits, a
  // polarity change, the hit gap across the timestamp wrap, the exact drop
  // equality and the strict movement and comb thresholds.
  localparam int N_DIR = 26;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{1'b1, R_VID, '{1'b0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'hFFFFFFFF}},
    '{1'b1, R_VID, '{1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'hFFFFFFFF}},
    '{1'b1, R_VID, '{1'b1, 24'h000000, 24'h000000, 1'b0, 32'h00000000}},
    '{1'b0, R_VID, '{1'b1, 24'd5000,   24'd3000,   1'b1, 32'd20}},
    '{1'b0, R_VID, '{1'b1, 24'd10,     24'd3000,   1'b0, 32'd40}},
    '{1'b0, R_VID, '{1'b1, 24'd5000,   24'd3000,   1'b1, 32'd60}},
    '{1'b0, R_VID, '{1'b1, 24'd10,     24'd3000,   1'b0, 32'd80}},
    '{1'b0, R_VID, '{1'b1, 24'd5000,   24'd3000,   1'b1, 32'd100}},
    '{1'b0, R_VID, '{1'b1, 24'd10,     24'd3000,   1'b0, 32'd300}},
    '{1'b0, R_VID, '{1'b1, 24'd5000,   24'd3000,   1'b1, 32'd320}},
    '{1'b0, R_VID, '{1'b1, 24'd10,     24'd3000,   1'b1, 32'd340}},
    '{1'b0, R_VID, '{1'b0, 24'h5A5A5A, 24'hA5A5A5, 1'b0, 32'h12345678}},
    '{1'b0, R_VID, '{1'b1, 24'd5000,   24'd3000,   1'b0, 32'hFFFFFFA0}},
    '{1'b0, R_VID, '{1'b1, 24'd10,     24'd3000,   1'b1, 32'hFFFFFFC0}},
    '{1'b0, R_VID, '{1'b1, 24'd5000,   24'd3000,   1'b0, 32'hFFFFFFE0}},
    '{1'b0, R_VID, '{1'b1, 24'd10,     24'd3000,   1'b1, 32'h00000010}},
    '{1'b0, R_VID, '{1'b1, 24'd5000,   24'd3000,   1'b0, 32'd30}},
    '{1'b0, R_VID, '{1'b1, 24'd10,     24'd3000,   1'b1, 32'd50}},
    '{1'b0, R_VID, '{1'b1, 24'd5000,   24'd3000,   1'b0, 32'd70}},
    '{1'b0, R_VID, '{1'b1, 24'd10,     24'd3000,   1'b1, 32'd90}},
    '{1'b0, R_VID, '{1'b1, 24'd5000,   24'd3000,   1'b0, 32'd110}},
    '{1'b0, R_VID, '{1'b1, 24'd1530,   24'd3000,   1'b1, 32'd130}},
    '{1'b0, R_VID, '{1'b1, 24'd5000,   24'd3000,   1'b0, 32'd150}},
    '{1'b0, R_VID, '{1'b1, 24'd10,     24'd100,    1'b1, 32'd170}},
    '{1'b0, R_VID, '{1'b1, 24'd150,    24'd3000,   1'b0, 32'd190}},
    '{1'b0, R_VID, '{1'b1, 24'd0,      24'd3000,   1'b1, 32'd210}}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // ---------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pal22_in_if #(.STAT_BITS(STAT_BITS_DEF)) in_if ();
  pal22_out_if                             out_if ();

  pal_22_pulldown_detector #(.STAT_BITS(STAT_BITS_DEF)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  res_t mode_exp_q [$];     // expected results, oldest first
  logic calm = 1'b0;        // both sides stop idling while set
  int   hold_ask = 0;       // bumped by the sender to request a hold-off
  int   n_errors = 0;
  int   n_fields = 0, n_skipped = 0, n_results = 0;
  int   n_changes = 0, n_film = 0, n_comb = 0, n_harder = 0;

  // Register copy, at reset values
  logic [PCT_W-1:0]      c_drop_pct = DROP_PCT_RST;
  logic [CFG_STAT_W-1:0] c_move_min = MOVE_MIN_RST;
  logic [CFG_STAT_W-1:0] c_comb_min = COMB_MIN_RST;
  logic [LOCK_W-1:0]     c_repeats  = REPEATS_RST;
  logic [CFG_STAT_W-1:0] c_mismatch = MISMATCH_RST;
  logic [CFG_STAT_W-1:0] c_margin   = RISE_MARG_RST;
  logic                  c_fallback = 1'b0;
  logic [CCNT_W-1:0]     c_comb_max = COMB_MAX_RST;

  // Detector state copy, at reset values
  mode_e                 s_mode      = MODE_VIDEO;
  logic [CFG_STAT_W-1:0] s_prev_comb = '0;
  logic                  s_prev_above = 1'b0;
  logic [1:0]            s_prev_pol  = POL_NONE;
  logic [RUN_W-1:0]      s_run       = '0;
  logic [RUN_W-1:0]      s_needed    = {2'b00, REPEATS_RST};
  logic [TIME_W-1:0]     s_last_hit  = '0;
  logic [FSS_W-1:0]      s_fss       = '0;
  logic [UNSURE_W-1:0]   s_unsure    = '0;
  logic                  s_pending   = 1'b0;
  logic [CCNT_W-1:0]     s_ccnt      = '0;

  // Stimulus generator state
  logic [TIME_W-1:0]     g_time = '0;
  logic                  g_odd = 1'b0;
  logic                  g_high_next = 1'b1;
  logic [CFG_STAT_W-1:0] g_high = 24'd5000;

  // ---------------------------------------------------------------------------
  // Mode predictor
  // ---------------------------------------------------------------------------
  // Film exit: straight to video, video with a harder lock (young film),
  // or comb mode with the run primed for a quick relock.
  function automatic void drop_out_of_film();
    if (c_fallback) begin
      s_mode = MODE_VIDEO;
      s_run  = '0;
    end else if (s_fss < FSS_LOCK_MIN) begin
      s_mode   = MODE_VIDEO;
      s_fss    = '0;
      s_needed = {c_repeats, 2'b00};
      s_run    = '0;
    end else begin
      s_ccnt    = '0;
      s_mode    = MODE_COMB;
      s_run     = s_needed;
      s_pending = 1'b1;
    end
  endfunction

  function automatic res_t predict_mode(field_t f);
    mode_e       start_mode;
    logic [63:0] last, scaled, limit;
    logic        dropped, same_pol;
    res_t        r;
    start_mode = s_mode;
    if (f.sv) begin
      // exact percentage test: comb*100 against low*(prev+100)
      last     = 64'(s_prev_comb);
      scaled   = 64'(f.comb) * 64'd100;
      limit    = 64'(c_drop_pct) * (last + 64'd100);
      dropped  = scaled < limit;
      same_pol = (s_prev_pol == {1'b0, f.odd});

      if (s_fss < FSS_SAT) s_fss = s_fss + 1'b1;

      if (s_pending) begin
        if (s_mode == MODE_VIDEO) begin
          s_run     = '0;
          s_pending = 1'b0;
        end else if (s_mode != MODE_COMB) begin
          s_pending = 1'b0;
        end
      end

      if (s_mode == MODE_VIDEO || s_mode == MODE_COMB) begin
        if (dropped && s_prev_above && f.diff > c_move_min && last > 64'(c_comb_min)) begin
          if (same_pol) begin
            if (s_run < s_needed) begin
              if (s_run == '0) s_run = RUN_W'(1);
              else if (f.now - s_last_hit < HIT_GAP_MS) s_run = s_run + 1'b1;
              else s_run = RUN_W'(1);
            end else if (s_fss > FSS_LOCK_MIN || s_mode == MODE_COMB) begin
              s_mode   = f.odd ? MODE_ODD : MODE_EVEN;
              s_needed = {2'b00, c_repeats};
              s_unsure = '0;
              s_fss    = '0;
            end
          end else begin
            s_prev_pol = {1'b0, f.odd};
            s_run      = RUN_W'(1);
          end
          s_last_hit = f.now;
        end
      end else begin
        if (f.diff >= c_mismatch && same_pol &&
            64'(f.comb) > last + 64'(c_margin) && f.comb > c_margin)
          drop_out_of_film();
        if (same_pol && f.diff >= c_mismatch) begin
          if (64'(f.comb) < last) begin
            if (64'(f.comb) + 64'(c_margin) < last) s_unsure = '0;
            else if (s_unsure != '0) s_unsure = s_unsure - 1'b1;
          end else begin
            if (s_unsure < UNSURE_SAT) s_unsure = s_unsure + 1'b1;
            if (s_unsure > UNSURE_LIMIT) drop_out_of_film();
          end
        end
      end

      s_prev_above = scaled > limit;
      s_prev_comb  = f.comb;

      if (s_mode == MODE_COMB) begin
        if (s_ccnt < CCNT_SAT) s_ccnt = s_ccnt + 1'b1;
        if (s_ccnt > c_comb_max) s_mode = MODE_VIDEO;
      end
    end
    r.mode         = s_mode;
    r.mode_changed = (s_mode != start_mode);
    r.lock_harder  = (s_needed != {2'b00, c_repeats});
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  // Fields mostly come at 50 Hz. Cadence alternates a high comb field with a low one,
  // so hits land every second field with one polarity; a skipped beat of the
  // pattern now and then moves the hits to the other polarity.
  function automatic field_t next_field(gen_kind_e kind);
    field_t      f;
    logic [31:0] step_ms;
    step_ms = ($urandom_range(99) < 80) ? 32'd20 : 32'($urandom_range(60));
    if ($urandom_range(199) == 0) step_ms = $urandom;
    g_time = g_time + step_ms;
    g_odd  = ~g_odd;
    f.sv   = ($urandom_range(99) >= 4);
    f.odd  = g_odd;
    f.now  = g_time;
    f.diff = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(60000, 2500));
    if (g_high_next) begin
      g_high = ($urandom_range(9) == 0) ? 24'($urandom_range(24'hFFFFFF, 200000))
                                        : 24'($urandom_range(200000, 2500));
      f.comb = g_high;
    end else begin
      f.comb = 24'($urandom_range(g_high / 40));
    end
    if ($urandom_range(49) != 0) g_high_next = ~g_high_next;

    if (kind == GEN_NOISY && $urandom_range(99) < 15) begin
      f.comb = 24'($urandom) >> $urandom_range(23);
      f.diff = 24'($urandom) >> $urandom_range(23);
    end else if (kind == GEN_RANDOM) begin
      f.comb = 24'($urandom) >> $urandom_range(23);
      f.diff = 24'($urandom) >> $urandom_range(23);
      f.odd  = 1'($urandom_range(1));
      if ($urandom_range(3) == 0) f.now = $urandom;
    end
    return f;
  endfunction

  function automatic cfg_t phase_settings(int ph);
    cfg_t c;
    case (ph)
      0: c = '{DROP_PCT_RST, MOVE_MIN_RST, COMB_MIN_RST, REPEATS_RST,
               MISMATCH_RST, RISE_MARG_RST, 1'b0, COMB_MAX_RST};
      // lowest thresholds, direct fallback, comb mode ends at once
      1: c = '{7'd100, 24'd0, 24'd0, 4'd1, 24'd0, 24'd0, 1'b1, 10'd0};
      // no drop ever counts, top thresholds, comb mode never ends
      2: c = '{7'd0, 24'hFFFFFF, 24'hFFFFFF, 4'd10, 24'd0, 24'hFFFFFF, 1'b0, 10'd1023};
      default: begin
        c.drop_pct     = 7'($urandom_range(90, 10));
        c.move_min     = 24'($urandom_range(2000));
        c.comb_min     = 24'($urandom_range(2000));
        c.repeats      = 4'($urandom_range(10, 1));
        c.mismatch_min = 24'($urandom_range(3000));
        c.rise_margin  = 24'($urandom_range(3000));
        c.fallback     = 1'($urandom_range(1));
        c.comb_max     = ($urandom_range(3) == 0) ? 10'd1000 : 10'($urandom_range(60));
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_DROP_PCT:  c_drop_pct = data[PCT_W-1:0];
      CFG_MOVE_MIN:  c_move_min = data;
      CFG_COMB_MIN:  c_comb_min = data;
      CFG_REPEATS: begin
        // a lock count write also reloads the required count
        c_repeats = data[LOCK_W-1:0];
        s_needed  = {2'b00, c_repeats};
      end
      CFG_MISMATCH:  c_mismatch = data;
      CFG_RISE_MARG: c_margin   = data;
      CFG_FALLBACK:  c_fallback = data[0];
      CFG_COMB_MAX:  c_comb_max = data[CCNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_settings(cfg_t c);
    write_reg(CFG_DROP_PCT,  CFG_DATA_W'(c.drop_pct));
    write_reg(CFG_MOVE_MIN,  c.move_min);
    write_reg(CFG_COMB_MIN,  c.comb_min);
    write_reg(CFG_REPEATS,   CFG_DATA_W'(c.repeats));
    write_reg(CFG_MISMATCH,  c.mismatch_min);
    write_reg(CFG_RISE_MARG, c.rise_margin);
    write_reg(CFG_FALLBACK,  CFG_DATA_W'(c.fallback));
    write_reg(CFG_COMB_MAX,  CFG_DATA_W'(c.comb_max));
    cfg_we_i <= 1'b0;
  endtask

  // Sender goes quiet until every outstanding mode beat has come back
  task automatic wait_for_modes();
    do begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end while (mode_exp_q.size() != 0);
  endtask

  // Offer one field; predict its mode at the accepting edge
  task automatic offer_field(field_t f, logic chk, res_t typed);
    res_t pred;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.stats_valid <= f.sv;
    in_if.comb_factor <= f.comb;
    in_if.field_diff  <= f.diff;
    in_if.odd_field   <= f.odd;
    in_if.now_ms      <= f.now;
    do @(posedge clk_i); while (!in_if.ready);
    pred = predict_mode(f);
    mode_exp_q.push_back(chk ? typed : pred);
    n_fields++;
    if (!f.sv) n_skipped++;
  endtask

  // ---------------------------------------------------------------------------
  // Field source: reset, directed table, then random phases
  // ---------------------------------------------------------------------------
  initial begin : field_source
    field_t    f;
    gen_kind_e kind;
    int        seg_len, n_ph, pick;
    logic      held, paused;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_DROP_PCT;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.stats_valid = 1'b0;
    in_if.comb_factor = '0;
    in_if.field_diff  = '0;
    in_if.odd_field   = 1'b0;
    in_if.now_ms      = '0;
    held   = 1'b0;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part runs on reset register values
    for (int i = 0; i < N_DIR; i++)
      offer_field(DIR_TAB[i].f, DIR_TAB[i].chk, DIR_TAB[i].exp_res);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_for_modes();
      program_settings(phase_settings(ph));
      calm = (ph == 2);               // one whole phase with no idling
      if (ph == 3) g_time = 32'hFFFFFF00;   // cadence across the timestamp wrap
      n_ph = 0;
      while (n_ph < FIELDS_PER_PH) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          kind    = GEN_CADENCE;
          seg_len = $urandom_range(260, 120);
        end else if (pick < 85) begin
          kind    = GEN_NOISY;
          seg_len = $urandom_range(120, 40);
        end else begin
          kind    = GEN_RANDOM;
          seg_len = $urandom_range(40, 10);
        end
        if (ph != 3 && $urandom_range(1) == 0) g_time = $urandom;
        for (int k = 0; k < seg_len && n_ph < FIELDS_PER_PH; k++) begin
          // receiver stalls for a long time while fields keep coming
          if (ph == 1 && n_ph == HOLD_AT && !held) begin
            held = 1'b1;
            hold_ask++;
          end
          // mid-phase drain with the sender quiet
          if (ph == 0 && n_ph == PAUSE_AT && !paused) begin
            paused = 1'b1;
            wait_for_modes();
          end
          f = next_field(kind);
          offer_field(f, 1'b0, R_VID);
          if (f.sv) n_ph++;
        end
      end
    end

    wait_for_modes();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d fields (%0d skipped) over %0d register settings, %0d results.",
             n_fields, n_skipped, N_PHASES + 1, n_results);
    $display("Mode changes %0d, film fields %0d, comb fields %0d, harder lock %0d.",
             n_changes, n_film, n_comb, n_harder);
    if (n_errors == 0 && mode_exp_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int served;
    served       = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (served != hold_ask) begin
        served = hold_ask;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_if.ready <= (calm || $urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endfunction

  res_t mode_exp;

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      if (mode_exp_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result beat, expected none, got mode %0d",
                 $time, out_if.mode);
      end else begin
        mode_exp = mode_exp_q.pop_front();
        check_field("mode",         mode_exp.mode,         out_if.mode);
        check_field("mode_changed", mode_exp.mode_changed, out_if.mode_changed);
        check_field("lock_harder",  mode_exp.lock_harder,  out_if.lock_harder);
        if (mode_exp.mode_changed) n_changes++;
        if (mode_exp.mode == MODE_ODD || mode_exp.mode == MODE_EVEN) n_film++;
        if (mode_exp.mode == MODE_COMB) n_comb++;
        if (mode_exp.lock_harder) n_harder++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without a beat on either channel
  // ---------------------------------------------------------------------------
  int stall_cnt = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, stall_cnt, mode_exp_q.size());
      $display("simulation failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

endmodule

[filelist.f]
design/pal22_pkg.sv
design/pal22_if.sv
design/pal22_cfg.sv
design/pal22_core.sv
design/pal22_22_pulldown_detector.sv
tb/tb.sv
